@@ rtl/wrsp_pkg.sv @@
// ----------------------------------------------------------------------------
// WAV RIFF stream parser package
// Shared types, codes and constants for the WAV byte-stream parser.
// ----------------------------------------------------------------------------
package wrsp_pkg;

    typedef enum logic [1:0] {
        KIND_FORMAT  = 2'd0,
        KIND_SAMPLE  = 2'd1,
        KIND_FILE_OK = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_SHORT      = 3'd0,
        ERR_NOT_RIFF   = 3'd1,
        ERR_SIZE       = 3'd2,
        ERR_NOT_WAVE   = 3'd3,
        ERR_BITS       = 3'd4,
        ERR_DATA_FIRST = 3'd5,
        ERR_NO_FMT     = 3'd6,
        ERR_NO_DATA    = 3'd7
    } t_err;

    typedef enum logic [3:0] {
        PH_RIFF_TAG   = 4'd0,
        PH_RIFF_SIZE  = 4'd1,
        PH_WAVE_TAG   = 4'd2,
        PH_CHUNK_ID   = 4'd3,
        PH_CHUNK_SIZE = 4'd4,
        PH_FMT_BODY   = 4'd5,
        PH_DATA_BODY  = 4'd6,
        PH_SKIP_BODY  = 4'd7,
        PH_IDLE       = 4'd8
    } t_phase;

    localparam logic [31:0] TAG_RIFF      = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE      = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT       = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA      = 32'h6174_6164;
    localparam logic [4:0]  TAG_BYTES     = 5'd4;
    localparam logic [4:0]  FMT_BODY_LEN  = 5'd16;
    localparam logic [15:0] BITS_REQUIRED = 16'd16;
    localparam logic [31:0] MIN_FILE_LEN  = 32'd44;
    localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = 3;
    localparam logic [QCNT_W-1:0] QUEUE_ROOM = 3'd2;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] sample_value;
        logic [15:0]        channel_index;
        logic [15:0]        channel_count;
        logic [31:0]        rate_of_samples;
        logic [31:0]        rate_of_bytes;
        logic [15:0]        alignment_of_block;
        logic [15:0]        format_tag;
        t_err               error_code;
        logic               last_of_run;
    } t_result;

    typedef struct packed {
        logic    has_a;
        t_result res_a;
        logic    has_b;
        t_result res_b;
    } t_step;

endpackage

@@ rtl/wrsp_core.sv @@
// ----------------------------------------------------------------------------
// WAV parser core
// Parse state and the per-byte step: tags, sizes, fmt body, samples, checks.
// ----------------------------------------------------------------------------
module wrsp_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_byte,
    input  logic           i_eof,
    output wrsp_pkg::t_step o_step
);
    import wrsp_pkg::*;

    t_phase       r_phase, n_phase;
    logic [4:0]   r_fbc, n_fbc;
    logic [31:0]  r_tag, n_tag;
    logic [31:0]  r_left, n_left;
    logic [31:0]  r_total, n_total;
    logic [31:0]  r_riff, n_riff;
    logic         r_fmt_seen, n_fmt_seen;
    logic         r_data_seen, n_data_seen;
    logic [127:0] r_fmt, n_fmt;
    logic [7:0]   r_low, n_low;
    logic [15:0]  r_chan, n_chan;
    logic         r_err, n_err;

    logic         a_fail;
    t_err         a_code;
    logic         a_fmt;
    logic         a_samp;

    logic [4:0]   fbc_inc;
    logic [31:0]  tag_dep;
    logic [31:0]  left_dep;
    logic [31:0]  riff_dep;
    logic [31:0]  left_dec;
    logic [16:0]  chan_inc;
    logic [15:0]  chans;

    function automatic logic [31:0] put_byte(input logic [31:0] v, input logic [7:0] b,
                                             input logic [1:0] pos);
        put_byte = v | (32'(b) << {pos, 3'b000});
    endfunction

    assign fbc_inc  = r_fbc + 5'd1;
    assign tag_dep  = put_byte(r_tag, i_byte, r_fbc[1:0]);
    assign left_dep = put_byte(r_left, i_byte, r_fbc[1:0]);
    assign riff_dep = put_byte(r_riff, i_byte, r_fbc[1:0]);
    assign left_dec = r_left - 32'd1;
    assign chans    = r_fmt[31:16];
    assign chan_inc = {1'b0, r_chan} + 17'd1;

    always_comb begin
        logic fmt_done;
        logic chunk_end;
        n_phase     = r_phase;
        n_fbc       = r_fbc;
        n_tag       = r_tag;
        n_left      = r_left;
        n_riff      = r_riff;
        n_fmt_seen  = r_fmt_seen;
        n_data_seen = r_data_seen;
        n_fmt       = r_fmt;
        n_low       = r_low;
        n_chan      = r_chan;
        n_err       = r_err;
        n_total     = (r_total == COUNT_MAX) ? r_total : r_total + 32'd1;
        a_fail      = 1'b0;
        a_code      = ERR_SHORT;
        a_fmt       = 1'b0;
        a_samp      = 1'b0;
        fmt_done    = 1'b0;
        chunk_end   = 1'b0;
        if (!r_err) begin
            unique case (r_phase)
                PH_RIFF_TAG, PH_WAVE_TAG: begin
                    n_tag = tag_dep;
                    n_fbc = fbc_inc;
                    if (fbc_inc == TAG_BYTES) begin
                        n_fbc = '0;
                        n_tag = '0;
                        if (r_phase == PH_RIFF_TAG) begin
                            if (tag_dep != TAG_RIFF) begin
                                a_fail = 1'b1;
                                a_code = ERR_NOT_RIFF;
                            end else begin
                                n_phase = PH_RIFF_SIZE;
                            end
                        end else if (tag_dep != TAG_WAVE) begin
                            a_fail = 1'b1;
                            a_code = ERR_NOT_WAVE;
                        end else begin
                            n_phase = PH_CHUNK_ID;
                        end
                    end
                end
                PH_RIFF_SIZE: begin
                    n_riff = riff_dep;
                    n_fbc  = fbc_inc;
                    if (fbc_inc == TAG_BYTES) begin
                        n_fbc   = '0;
                        n_tag   = '0;
                        n_phase = PH_WAVE_TAG;
                    end
                end
                PH_CHUNK_ID: begin
                    n_tag = tag_dep;
                    n_fbc = fbc_inc;
                    if (fbc_inc == TAG_BYTES) begin
                        n_fbc  = '0;
                        n_left = '0;
                        if (tag_dep == TAG_DATA && !r_fmt_seen) begin
                            a_fail = 1'b1;
                            a_code = ERR_DATA_FIRST;
                        end else begin
                            if (tag_dep == TAG_FMT) begin
                                n_fmt_seen = 1'b1;
                                n_fmt      = '0;
                            end else if (tag_dep == TAG_DATA) begin
                                n_data_seen = 1'b1;
                                n_chan      = '0;
                            end
                            n_phase = PH_CHUNK_SIZE;
                        end
                    end
                end
                PH_CHUNK_SIZE: begin
                    n_left = left_dep;
                    n_fbc  = fbc_inc;
                    if (fbc_inc == TAG_BYTES) begin
                        n_fbc = '0;
                        if (r_tag == TAG_FMT) begin
                            if (left_dep == '0) begin
                                fmt_done  = 1'b1;
                                chunk_end = 1'b1;
                            end else begin
                                n_phase = PH_FMT_BODY;
                            end
                        end else if (left_dep == '0) begin
                            n_phase = PH_CHUNK_ID;
                            n_tag   = '0;
                        end else begin
                            n_phase = (r_tag == TAG_DATA) ? PH_DATA_BODY : PH_SKIP_BODY;
                        end
                    end
                end
                PH_FMT_BODY: begin
                    n_left    = left_dec;
                    chunk_end = (left_dec == '0);
                    if (r_fbc < FMT_BODY_LEN) begin
                        n_fmt[{r_fbc[3:0], 3'b000} +: 8] =
                            r_fmt[{r_fbc[3:0], 3'b000} +: 8] | i_byte;
                        n_fbc = fbc_inc;
                        if (fbc_inc == FMT_BODY_LEN) begin
                            fmt_done = 1'b1;
                        end else if (left_dec == '0) begin
                            n_fbc    = FMT_BODY_LEN;
                            fmt_done = 1'b1;
                        end
                    end
                end
                PH_DATA_BODY: begin
                    if (r_fbc == '0) begin
                        n_low = i_byte;
                        n_fbc = 5'd1;
                    end else begin
                        a_samp = 1'b1;
                        n_chan = (chan_inc >= {1'b0, chans}) ? '0 : chan_inc[15:0];
                        n_fbc  = '0;
                    end
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_CHUNK_ID;
                        n_fbc   = '0;
                        n_tag   = '0;
                    end
                end
                PH_SKIP_BODY: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_CHUNK_ID;
                        n_fbc   = '0;
                        n_tag   = '0;
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                end
            endcase
            if (fmt_done) begin
                if (n_fmt[127:112] != BITS_REQUIRED) begin
                    a_fail = 1'b1;
                    a_code = ERR_BITS;
                end else begin
                    a_fmt = 1'b1;
                end
            end
            if (chunk_end && !a_fail) begin
                n_phase = PH_CHUNK_ID;
                n_fbc   = '0;
                n_tag   = '0;
            end
            if (a_fail) begin
                n_err   = 1'b1;
                n_phase = PH_IDLE;
            end
        end
    end

    always_comb begin
        t_result ra;
        t_result rb;
        ra = '0;
        rb = '0;
        if (a_fail) begin
            ra.kind       = KIND_ERROR;
            ra.error_code = a_code;
        end else if (a_fmt) begin
            ra.kind               = KIND_FORMAT;
            ra.channel_count      = n_fmt[31:16];
            ra.rate_of_samples    = n_fmt[63:32];
            ra.rate_of_bytes      = n_fmt[95:64];
            ra.alignment_of_block = n_fmt[111:96];
            ra.format_tag         = n_fmt[15:0];
        end else if (a_samp) begin
            ra.kind          = KIND_SAMPLE;
            ra.sample_value  = signed'({i_byte, r_low});
            ra.channel_index = r_chan;
        end
        priority if (n_total < MIN_FILE_LEN) begin
            rb.kind       = KIND_ERROR;
            rb.error_code = ERR_SHORT;
        end else if (n_riff > n_total) begin
            rb.kind       = KIND_ERROR;
            rb.error_code = ERR_SIZE;
        end else if (!(n_phase == PH_CHUNK_ID && n_fbc == '0)) begin
            rb.kind       = KIND_ERROR;
            rb.error_code = ERR_SIZE;
        end else if (!n_fmt_seen) begin
            rb.kind       = KIND_ERROR;
            rb.error_code = ERR_NO_FMT;
        end else if (!n_data_seen) begin
            rb.kind       = KIND_ERROR;
            rb.error_code = ERR_NO_DATA;
        end else begin
            rb.kind = KIND_FILE_OK;
        end
        o_step.has_b       = i_fire && i_eof && !n_err;
        o_step.has_a       = i_fire && (a_fail || a_fmt || a_samp);
        ra.last_of_run     = !o_step.has_b;
        rb.last_of_run     = 1'b1;
        o_step.res_a       = ra;
        o_step.res_b       = rb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_eof)) begin
            r_phase     <= PH_RIFF_TAG;
            r_fbc       <= '0;
            r_tag       <= '0;
            r_left      <= '0;
            r_total     <= '0;
            r_riff      <= '0;
            r_fmt_seen  <= 1'b0;
            r_data_seen <= 1'b0;
            r_fmt       <= '0;
            r_low       <= '0;
            r_chan      <= '0;
            r_err       <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_fbc       <= n_fbc;
            r_tag       <= n_tag;
            r_left      <= n_left;
            r_total     <= n_total;
            r_riff      <= n_riff;
            r_fmt_seen  <= n_fmt_seen;
            r_data_seen <= n_data_seen;
            r_fmt       <= n_fmt;
            r_low       <= n_low;
            r_chan      <= n_chan;
            r_err       <= n_err;
        end
    end

endmodule

@@ rtl/wrsp_queue.sv @@
// ----------------------------------------------------------------------------
// WAV parser result queue
// Four-slot shifting queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module wrsp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wrsp_pkg::t_step  i_step,
    input  logic             i_pop,
    output wrsp_pkg::t_result o_head,
    output logic             o_valid,
    output logic             o_room
);
    import wrsp_pkg::*;

    t_result           r_q [QUEUE_DEPTH];
    t_result           n_q [QUEUE_DEPTH];
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic [QCNT_W-1:0] base;
    logic [1:0]        idx0;
    logic [1:0]        idx1;
    logic [1:0]        push_n;
    t_result           first;

    assign o_head  = r_q[0];
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= QUEUE_ROOM);
    assign base    = r_cnt - QCNT_W'(i_pop);
    assign idx0    = base[1:0];
    assign idx1    = idx0 + 2'd1;
    assign push_n  = 2'(i_step.has_a) + 2'(i_step.has_b);
    assign first   = i_step.has_a ? i_step.res_a : i_step.res_b;

    always_comb begin
        n_q = r_q;
        if (i_pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        if (push_n != 2'd0) begin
            n_q[idx0] = first;
        end
        if (push_n == 2'd2) begin
            n_q[idx1] = i_step.res_b;
        end
        n_cnt = base + QCNT_W'(push_n);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/wav_riff_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// WAV RIFF stream parser
// Byte-serial WAV parser: format info, 16-bit PCM samples, end-of-file status.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       to block   i_valid / o_ready   i_data_byte, i_end_of_file
//  out      from block o_valid / i_ready   o_kind ... o_last_of_run
//
//  One byte per cycle while the result queue has room; a byte is registered,
//  then stepped through the parser; its results are registered in the queue.
//  A byte with two results (final byte of a file) fills two queue slots.
//  Input stalls only when the four-slot result queue holds more than two.
//  Synchronous active-low reset; the final byte restarts the parser.
// ----------------------------------------------------------------------------
module wav_riff_stream_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_file,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_sample_value,
    output logic [15:0]        o_channel_index,
    output logic [15:0]        o_channel_count,
    output logic [31:0]        o_rate_of_samples,
    output logic [31:0]        o_rate_of_bytes,
    output logic [15:0]        o_alignment_of_block,
    output logic [15:0]        o_format_tag,
    output logic [2:0]         o_error_code,
    output logic               o_last_of_run
);
    import wrsp_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_eof;
    logic       fire;
    logic       room;
    logic       pop;
    t_step      s_step;
    t_result    head;

    assign fire    = r_in_vld && room;
    assign o_ready = !r_in_vld || fire;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    wrsp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_eof   (r_in_eof),
        .o_step  (s_step)
    );

    wrsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s_step),
        .i_pop   (pop),
        .o_head  (head),
        .o_valid (o_valid),
        .o_room  (room)
    );

    assign o_kind               = head.kind;
    assign o_sample_value       = head.sample_value;
    assign o_channel_index      = head.channel_index;
    assign o_channel_count      = head.channel_count;
    assign o_rate_of_samples    = head.rate_of_samples;
    assign o_rate_of_bytes      = head.rate_of_bytes;
    assign o_alignment_of_block = head.alignment_of_block;
    assign o_format_tag         = head.format_tag;
    assign o_error_code         = head.error_code;
    assign o_last_of_run        = head.last_of_run;

`ifndef SYNTH
    a_status_on_eof : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_step.has_b |-> (fire && r_in_eof))
        else $error("status transfer without final byte");

    a_single_error : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_step.has_a && s_step.has_b) |-> (s_step.res_a.kind != KIND_ERROR))
        else $error("two results after an error");

    a_result_shown : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_step.has_a || s_step.has_b) |=> o_valid)
        else $error("result lost");
`endif

endmodule
